FILE: hw/rtl/asc_pkg.sv
package asc_pkg;

  // Repeat codes held in the alarm slots
  localparam logic [3:0] REP_OFF      = 4'd0;
  localparam logic [3:0] REP_LAST_DAY = 4'd7;
  localparam logic [3:0] REP_ONCE     = 4'd8;
  localparam logic [3:0] REP_DAILY    = 4'd9;
  localparam logic [3:0] REP_WORKDAYS = 4'd10;
  localparam logic [3:0] REP_WEEKEND  = 4'd11;

  // Last working day of the week (Friday)
  localparam logic [2:0] LAST_WORKDAY = 3'd5;

  // An alarm matches only in the first seconds of its minute
  localparam logic [5:0] MATCH_SECONDS = 6'd2;

  typedef enum logic [1:0] {
    CFG_RING_MINUTES = 2'd0,
    CFG_OFF_HOUR     = 2'd1,
    CFG_ON_HOUR      = 2'd2
  } asc_cfg_e;

  typedef enum logic [1:0] {
    DRIVE_KEEP = 2'd0,
    DRIVE_OFF  = 2'd1,
    DRIVE_ON   = 2'd2
  } asc_drive_e;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [3:0] repeat_code;
  } asc_alarm_t;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [2:0] weekday;
  } asc_time_t;

  typedef struct packed {
    logic       mode;
    logic [1:0] slot;
    asc_alarm_t alarm;
    asc_time_t  now;
    logic       stop_pressed;
    logic       key_low;
    logic [2:0] song_pick;
  } asc_item_t;

  typedef struct packed {
    logic       show_warning;
    logic [2:0] song_start;
    logic       stop_sound;
    asc_drive_e drive;
    logic       ringing;
  } asc_result_t;

endpackage

FILE: hw/rtl/asc_match.sv
module asc_match #(
  parameter int NUM_ALARMS = 3
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_en_i,
  input  logic [1:0]        wr_slot_i,
  input  asc_pkg::asc_alarm_t wr_alarm_i,
  input  logic              tick_en_i,
  input  asc_pkg::asc_time_t  now_i,
  output logic              matched_o
);

  asc_pkg::asc_alarm_t [NUM_ALARMS-1:0] slot_q, slot_d;
  logic [NUM_ALARMS-1:0] hit;

  function automatic logic day_selected(input logic [3:0] code, input logic [2:0] wd);
    logic sel;
    sel = 1'b0;
    if (code == asc_pkg::REP_OFF) begin
      sel = 1'b0;
    end else if (code <= asc_pkg::REP_LAST_DAY) begin
      sel = (code == {1'b0, wd});
    end else if (code == asc_pkg::REP_ONCE || code == asc_pkg::REP_DAILY) begin
      sel = 1'b1;
    end else if (code == asc_pkg::REP_WORKDAYS) begin
      sel = (wd <= asc_pkg::LAST_WORKDAY);
    end else if (code == asc_pkg::REP_WEEKEND) begin
      sel = (wd > asc_pkg::LAST_WORKDAY);
    end
    return sel;
  endfunction

  always_comb begin
    slot_d = slot_q;
    for (int k = 0; k < NUM_ALARMS; k++) begin
      hit[k] = day_selected(slot_q[k].repeat_code, now_i.weekday) &&
               slot_q[k].hour == now_i.hour && slot_q[k].minute == now_i.minute &&
               now_i.second < asc_pkg::MATCH_SECONDS;
      if (wr_en_i && int'(wr_slot_i) == k) begin
        slot_d[k] = wr_alarm_i;
      end else if (tick_en_i && hit[k] && slot_q[k].repeat_code == asc_pkg::REP_ONCE) begin
        // one-shot alarm retires only once it has fired
        slot_d[k].repeat_code = asc_pkg::REP_OFF;
      end
    end
  end

  assign matched_o = tick_en_i && (|hit);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else begin
      slot_q <= slot_d;
    end
  end

endmodule

FILE: hw/rtl/alarm_schedule_controller.sv
// Channel   Direction  Handshake               Payload
// in        input      in_valid_i / in_stall_o  mode_i .. song_pick_i
// out       output     out_valid_o/ out_stall_i show_warning_o .. ringing_o
// cfg       input      cfg_valid_i/ cfg_ready_o cfg_index_i, cfg_data_i
//
// One item per cycle while the output is not stalled. An item is taken into the
// input register, worked combinationally against the alarm slots and counters,
// and is loaded into the result register when the output advances.
// Asynchronous active-low reset sets the flags, counters and settings; the input
// and result registers are not reset. A stall on the output holds both stages;
// the input takes a new item whenever its register is empty or moves on.
module alarm_schedule_controller #(
  parameter int NUM_ALARMS       = 3,
  parameter int KEY_SAMPLE_TICKS = 20,
  parameter int TICKS_PER_MINUTE = 60
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       mode_i,
  input  logic [1:0] slot_i,
  input  logic [4:0] set_hour_i,
  input  logic [5:0] set_minute_i,
  input  logic [3:0] set_repeat_i,
  input  logic [4:0] hour_i,
  input  logic [5:0] minute_i,
  input  logic [5:0] second_i,
  input  logic [2:0] weekday_i,
  input  logic       stop_pressed_i,
  input  logic       key_low_i,
  input  logic [2:0] song_pick_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       show_warning_o,
  output logic [2:0] song_start_o,
  output logic       stop_sound_o,
  output logic [1:0] display_drive_o,
  output logic       ringing_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);

  localparam int LenMax = 255 * TICKS_PER_MINUTE;
  localparam int CntW   = $clog2(LenMax + 3);
  localparam int KeyW   = $clog2(KEY_SAMPLE_TICKS + 2);

  asc_pkg::asc_item_t   item_q;
  asc_pkg::asc_result_t res_q, res_d;
  logic                 in_valid_q, out_valid_q;
  logic                 advance, fire, tick, matched;

  logic [7:0]      ring_minutes_q;
  logic [4:0]      off_hour_q, on_hour_q;
  logic            ring_pending_q, ring_pending_d;
  logic [CntW-1:0] ring_count_q, ring_count_d;
  logic            manual_on_q, manual_on_d;
  logic [KeyW-1:0] key_count_q, key_count_d;
  logic [CntW-1:0] ring_len;
  logic            stop;

  assign advance     = !out_valid_q || !out_stall_i;
  assign fire        = in_valid_q && advance;
  assign tick        = fire && !item_q.mode;
  assign in_stall_o  = in_valid_q && !advance;
  assign cfg_ready_o = 1'b1;

  assign ring_len = CntW'(ring_minutes_q) * CntW'(TICKS_PER_MINUTE);

  asc_match #(
    .NUM_ALARMS(NUM_ALARMS)
  ) u_match (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (fire && item_q.mode),
    .wr_slot_i  (item_q.slot),
    .wr_alarm_i (item_q.alarm),
    .tick_en_i  (tick),
    .now_i      (item_q.now),
    .matched_o  (matched)
  );

  always_comb begin
    ring_pending_d = ring_pending_q;
    ring_count_d   = ring_count_q;
    manual_on_d    = manual_on_q;
    key_count_d    = key_count_q;
    res_d          = '0;
    res_d.drive    = asc_pkg::DRIVE_KEEP;
    stop           = item_q.stop_pressed && !matched;

    if (tick) begin
      if (ring_pending_q || matched) begin
        ring_pending_d = 1'b0;
        if (ring_count_q == '0) begin
          res_d.show_warning = 1'b1;
          res_d.song_start   = item_q.song_pick;
        end
        ring_count_d = ring_count_q + 1'b1;
        if (ring_count_d < ring_len) begin
          ring_pending_d = 1'b1;
        end else if (ring_count_d == ring_len) begin
          res_d.song_start = item_q.song_pick;
          ring_count_d     = '0;
        end else begin
          ring_count_d = '0;
        end
      end

      // stop ends ringing on the next tick without a closing song
      if (stop) begin
        if (ring_count_d != '0) begin
          ring_count_d = ring_len + 1'b1;
        end
        res_d.stop_sound = 1'b1;
      end

      if (!manual_on_q) begin
        if (off_hour_q <= item_q.now.hour || on_hour_q > item_q.now.hour) begin
          res_d.drive = asc_pkg::DRIVE_OFF;
        end else if (on_hour_q == item_q.now.hour) begin
          res_d.drive = asc_pkg::DRIVE_ON;
        end
      end

      key_count_d = key_count_q + 1'b1;
      if (key_count_d > KeyW'(KEY_SAMPLE_TICKS)) begin
        key_count_d = '0;
        manual_on_d = item_q.key_low;
        if (item_q.key_low) begin
          res_d.stop_sound = 1'b1;
          res_d.drive      = asc_pkg::DRIVE_ON;
        end
      end
    end

    res_d.ringing = (ring_count_d != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q     <= 1'b0;
      out_valid_q    <= 1'b0;
      ring_minutes_q <= 8'd1;
      off_hour_q     <= 5'd22;
      on_hour_q      <= 5'd7;
      ring_pending_q <= 1'b0;
      ring_count_q   <= '0;
      manual_on_q    <= 1'b0;
      key_count_q    <= '0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          asc_pkg::CFG_RING_MINUTES: ring_minutes_q <= cfg_data_i;
          asc_pkg::CFG_OFF_HOUR:     off_hour_q     <= cfg_data_i[4:0];
          asc_pkg::CFG_ON_HOUR:      on_hour_q      <= cfg_data_i[4:0];
          default: ;
        endcase
      end
      ring_pending_q <= ring_pending_d;
      ring_count_q   <= ring_count_d;
      manual_on_q    <= manual_on_d;
      key_count_q    <= key_count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o) begin
      item_q.mode              <= mode_i;
      item_q.slot              <= slot_i;
      item_q.alarm.hour        <= set_hour_i;
      item_q.alarm.minute      <= set_minute_i;
      item_q.alarm.repeat_code <= set_repeat_i;
      item_q.now.hour          <= hour_i;
      item_q.now.minute        <= minute_i;
      item_q.now.second        <= second_i;
      item_q.now.weekday       <= weekday_i;
      item_q.stop_pressed      <= stop_pressed_i;
      item_q.key_low           <= key_low_i;
      item_q.song_pick         <= song_pick_i;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign show_warning_o  = res_q.show_warning;
  assign song_start_o    = res_q.song_start;
  assign stop_sound_o    = res_q.stop_sound;
  assign display_drive_o = res_q.drive;
  assign ringing_o       = res_q.ringing;

endmodule

FILE: sim/alarm_schedule_controller_test.sv
`timescale 1ns / 100ps

module alarm_schedule_controller_test;

  localparam int NUM_SLOTS     = 3;
  localparam int KEY_PERIOD    = 20;
  localparam int TICKS_PER_MIN = 60;
  localparam int QUIET_LIMIT   = 1000;
  localparam int TARGET_ITEMS  = 1800;

  // repeat codes that the package leaves unnamed
  localparam logic [3:0] REP_WEDNESDAY = 4'd3;
  localparam logic [3:0] REP_SPARE_LO  = 4'd12;
  localparam logic [3:0] REP_SPARE_HI  = 4'd15;

  logic       clk_i          = 1'b0;
  logic       rst_ni         = 1'b0;
  logic       in_valid_i     = 1'b0;
  logic       in_stall_o;
  logic       mode_i         = 1'b0;
  logic [1:0] slot_i         = '0;
  logic [4:0] set_hour_i     = '0;
  logic [5:0] set_minute_i   = '0;
  logic [3:0] set_repeat_i   = '0;
  logic [4:0] hour_i         = '0;
  logic [5:0] minute_i       = '0;
  logic [5:0] second_i       = '0;
  logic [2:0] weekday_i      = '0;
  logic       stop_pressed_i = 1'b0;
  logic       key_low_i      = 1'b0;
  logic [2:0] song_pick_i    = '0;
  logic       out_valid_o;
  logic       out_stall_i    = 1'b0;
  logic       show_warning_o;
  logic [2:0] song_start_o;
  logic       stop_sound_o;
  logic [1:0] display_drive_o;
  logic       ringing_o;
  logic       cfg_valid_i    = 1'b0;
  logic [1:0] cfg_index_i    = asc_pkg::CFG_RING_MINUTES;
  logic [7:0] cfg_data_i     = '0;
  logic       cfg_ready_o;

  // schedule state as the block should hold it
  logic [4:0]  slot_hour   [NUM_SLOTS] = '{default: '0};
  logic [5:0]  slot_minute [NUM_SLOTS] = '{default: '0};
  logic [3:0]  slot_rep    [NUM_SLOTS] = '{default: '0};
  logic        ring_armed       = 1'b0;
  logic [13:0] ring_ticks       = '0;
  logic        display_forced   = 1'b0;
  logic [4:0]  key_ticks        = '0;
  logic [7:0]  ring_minutes_cfg = 8'd1;
  logic [4:0]  off_hour_cfg     = 5'd22;
  logic [4:0]  on_hour_cfg      = 5'd7;

  asc_pkg::asc_item_t   queued_requests[$];
  asc_pkg::asc_result_t awaited_responses[$];
  int requests_queued = 0;
  int requests_taken  = 0;
  int responses_seen  = 0;
  int mismatches      = 0;
  bit in_took  = 1'b0;
  bit out_took = 1'b0;
  int gap_left   = 0;
  int stall_left = 0;

  // alarm slots as written by the stimulus, and the simulated wall clock
  int plan_hour [4];
  int plan_minute [4];
  int plan_rep [4];
  int c_hr, c_mn, c_sc, c_wd;

  alarm_schedule_controller uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mode_i         (mode_i),
    .slot_i         (slot_i),
    .set_hour_i     (set_hour_i),
    .set_minute_i   (set_minute_i),
    .set_repeat_i   (set_repeat_i),
    .hour_i         (hour_i),
    .minute_i       (minute_i),
    .second_i       (second_i),
    .weekday_i      (weekday_i),
    .stop_pressed_i (stop_pressed_i),
    .key_low_i      (key_low_i),
    .song_pick_i    (song_pick_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .show_warning_o (show_warning_o),
    .song_start_o   (song_start_o),
    .stop_sound_o   (stop_sound_o),
    .display_drive_o(display_drive_o),
    .ringing_o      (ringing_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic bit day_selected(logic [3:0] code, logic [2:0] wd);
    if (code == asc_pkg::REP_OFF) return 1'b0;
    if (code <= asc_pkg::REP_LAST_DAY) return code == {1'b0, wd};
    if (code == asc_pkg::REP_ONCE || code == asc_pkg::REP_DAILY) return 1'b1;
    if (code == asc_pkg::REP_WORKDAYS) return wd <= asc_pkg::LAST_WORKDAY;
    if (code == asc_pkg::REP_WEEKEND) return wd > asc_pkg::LAST_WORKDAY;
    return 1'b0;
  endfunction

  function automatic asc_pkg::asc_result_t advance_schedule(asc_pkg::asc_item_t it);
    asc_pkg::asc_result_t r;
    logic [13:0] span;
    logic        hit;
    logic        stop_req;
    int          k;
    r = '0;
    r.drive = asc_pkg::DRIVE_KEEP;
    if (it.mode) begin
      if (it.slot < NUM_SLOTS) begin
        slot_hour[it.slot]   = it.alarm.hour;
        slot_minute[it.slot] = it.alarm.minute;
        slot_rep[it.slot]    = it.alarm.repeat_code;
      end
    end else begin
      span = 14'(ring_minutes_cfg * TICKS_PER_MIN);
      hit = 1'b0;
      stop_req = it.stop_pressed;
      for (k = 0; k < NUM_SLOTS; k++) begin
        if (day_selected(slot_rep[k], it.now.weekday) && slot_hour[k] == it.now.hour &&
            slot_minute[k] == it.now.minute && it.now.second < asc_pkg::MATCH_SECONDS) begin
          hit = 1'b1;
          ring_armed = 1'b1;
          if (slot_rep[k] == asc_pkg::REP_ONCE) slot_rep[k] = asc_pkg::REP_OFF;
        end
      end
      // drop a stop press that lands on a matching tick
      if (hit) stop_req = 1'b0;
      if (ring_armed) begin
        ring_armed = 1'b0;
        if (ring_ticks == 0) begin
          r.show_warning = 1'b1;
          r.song_start = it.song_pick;
        end
        ring_ticks = ring_ticks + 14'd1;
        if (ring_ticks < span) begin
          ring_armed = 1'b1;
        end else if (ring_ticks == span) begin
          r.song_start = it.song_pick;
          ring_ticks = '0;
        end else begin
          ring_ticks = '0;
        end
      end
      if (stop_req) begin
        if (ring_ticks != 0) ring_ticks = span + 14'd1;
        r.stop_sound = 1'b1;
      end
      if (!display_forced) begin
        if (off_hour_cfg <= it.now.hour || on_hour_cfg > it.now.hour)
          r.drive = asc_pkg::DRIVE_OFF;
        else if (on_hour_cfg == it.now.hour)
          r.drive = asc_pkg::DRIVE_ON;
      end
      key_ticks = key_ticks + 5'd1;
      if (key_ticks > KEY_PERIOD) begin
        key_ticks = '0;
        if (it.key_low) begin
          display_forced = 1'b1;
          r.stop_sound = 1'b1;
          r.drive = asc_pkg::DRIVE_ON;
        end else begin
          display_forced = 1'b0;
        end
      end
    end
    r.ringing = (ring_ticks != 0);
    return r;
  endfunction

  task automatic compare_field(string name, int got, int want);
    if (got != want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  task automatic queue_tick(int hr, int mn, int sc, int wd, int stop_req, int key, int pick);
    asc_pkg::asc_item_t it;
    it.mode = 1'b0;
    it.slot = 2'($urandom_range(0, 3));
    it.alarm = 15'($urandom);
    it.now.hour = 5'(hr);
    it.now.minute = 6'(mn);
    it.now.second = 6'(sc);
    it.now.weekday = 3'(wd);
    it.stop_pressed = 1'(stop_req);
    it.key_low = 1'(key);
    it.song_pick = 3'(pick);
    queued_requests.push_back(it);
    requests_queued++;
  endtask

  task automatic queue_write(int s, int hr, int mn, int rep);
    asc_pkg::asc_item_t it;
    it.mode = 1'b1;
    it.slot = 2'(s);
    it.alarm.hour = 5'(hr);
    it.alarm.minute = 6'(mn);
    it.alarm.repeat_code = 4'(rep);
    it.now = 20'($urandom);
    it.stop_pressed = 1'($urandom_range(0, 1));
    it.key_low = 1'($urandom_range(0, 1));
    it.song_pick = 3'($urandom_range(0, 7));
    plan_hour[s] = hr;
    plan_minute[s] = mn;
    plan_rep[s] = rep;
    queued_requests.push_back(it);
    requests_queued++;
  endtask

  // move the wall clock to the first seconds of an alarm's minute
  task automatic aim_clock(int t);
    c_hr = plan_hour[t];
    c_mn = plan_minute[t];
    c_sc = $urandom_range(0, 3);
    if (plan_rep[t] >= 1 && plan_rep[t] <= asc_pkg::REP_LAST_DAY &&
        $urandom_range(0, 3) != 0)
      c_wd = plan_rep[t];
    else if (plan_rep[t] == asc_pkg::REP_WEEKEND)
      c_wd = $urandom_range(asc_pkg::LAST_WORKDAY + 1, 7);
    else
      c_wd = $urandom_range(1, 7);
  endtask

  // wait until every queued item has been answered, then let the pipe empty
  task automatic settle();
    while (requests_taken != requests_queued || awaited_responses.size() != 0)
      @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(asc_pkg::asc_cfg_e idx, logic [7:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      asc_pkg::CFG_RING_MINUTES: ring_minutes_cfg = val;
      asc_pkg::CFG_OFF_HOUR:     off_hour_cfg = val[4:0];
      asc_pkg::CFG_ON_HOUR:      on_hour_cfg = val[4:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    asc_pkg::asc_item_t   seen;
    asc_pkg::asc_result_t want;
    if (rst_ni) begin
      in_took  = in_valid_i && !in_stall_o;
      out_took = out_valid_o && !out_stall_i;
      if (in_took) begin
        seen.mode = mode_i;
        seen.slot = slot_i;
        seen.alarm.hour = set_hour_i;
        seen.alarm.minute = set_minute_i;
        seen.alarm.repeat_code = set_repeat_i;
        seen.now.hour = hour_i;
        seen.now.minute = minute_i;
        seen.now.second = second_i;
        seen.now.weekday = weekday_i;
        seen.stop_pressed = stop_pressed_i;
        seen.key_low = key_low_i;
        seen.song_pick = song_pick_i;
        requests_taken++;
        awaited_responses.push_back(advance_schedule(seen));
      end
      if (out_took) begin
        responses_seen++;
        if (awaited_responses.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("%0t: result with none awaited", $time);
        end else begin
          want = awaited_responses.pop_front();
          compare_field("show_warning", show_warning_o, want.show_warning);
          compare_field("song_start", song_start_o, want.song_start);
          compare_field("stop_sound", stop_sound_o, want.stop_sound);
          compare_field("display_drive", display_drive_o, want.drive);
          compare_field("ringing", ringing_o, want.ringing);
        end
      end
    end
  end

  always @(negedge clk_i) begin
    asc_pkg::asc_item_t next_req;
    // hold a stalled item
    if (rst_ni && !(in_valid_i && !in_took)) begin
      if (gap_left > 0) begin
        in_valid_i <= 1'b0;
        gap_left--;
      end else if (queued_requests.size() != 0) begin
        next_req = queued_requests.pop_front();
        mode_i         <= next_req.mode;
        slot_i         <= next_req.slot;
        set_hour_i     <= next_req.alarm.hour;
        set_minute_i   <= next_req.alarm.minute;
        set_repeat_i   <= next_req.alarm.repeat_code;
        hour_i         <= next_req.now.hour;
        minute_i       <= next_req.now.minute;
        second_i       <= next_req.now.second;
        weekday_i      <= next_req.now.weekday;
        stop_pressed_i <= next_req.stop_pressed;
        key_low_i      <= next_req.key_low;
        song_pick_i    <= next_req.song_pick;
        in_valid_i     <= 1'b1;
        gap_left = ((requests_taken / 64) % 5 == 2) ? 0 : $urandom_range(0, 4);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (out_took) stall_left = ((responses_seen / 50) % 4 == 1) ? 0 : $urandom_range(0, 4);
    out_stall_i <= (stall_left > 0);
    if (stall_left > 0) stall_left--;
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet = 0;
      else
        quiet++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    int phase, n, r, t, s;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset settings: one-minute ring, display off from 22 until 7
    queue_tick(0, 0, 0, 1, 1, 0, 1);
    queue_write(0, 6, 30, asc_pkg::REP_ONCE);
    queue_write(1, 6, 30, REP_SPARE_LO);
    queue_write(2, 7, 0, asc_pkg::REP_DAILY);
    queue_write(3, 31, 63, REP_SPARE_HI);
    queue_tick(6, 30, 0, 3, 1, 0, 5);
    queue_tick(6, 30, 1, 3, 0, 0, 3);
    queue_tick(6, 30, 2, 3, 1, 0, 3);
    queue_tick(6, 30, 3, 3, 0, 0, 3);
    queue_tick(7, 0, 0, 7, 0, 1, 2);
    queue_tick(7, 0, 2, 7, 1, 1, 2);
    queue_tick(23, 59, 59, 7, 0, 1, 4);
    settle();

    // zero ring length, display window at its extremes
    write_reg(asc_pkg::CFG_RING_MINUTES, 8'd0);
    write_reg(asc_pkg::CFG_OFF_HOUR, 8'd23);
    write_reg(asc_pkg::CFG_ON_HOUR, 8'd0);
    queue_write(0, 8, 0, asc_pkg::REP_WORKDAYS);
    queue_write(1, 9, 15, asc_pkg::REP_WEEKEND);
    queue_write(2, 10, 20, REP_WEDNESDAY);
    queue_tick(8, 0, 0, 5, 0, 0, 4);
    queue_tick(8, 0, 1, 5, 0, 0, 1);
    queue_tick(8, 0, 0, 6, 0, 0, 1);
    queue_tick(9, 15, 1, 6, 0, 0, 2);
    queue_tick(10, 20, 0, 3, 0, 0, 3);
    queue_tick(10, 20, 0, 4, 0, 0, 3);
    queue_tick(23, 0, 0, 1, 0, 0, 5);
    queue_tick(0, 0, 0, 1, 0, 0, 5);

    c_hr = 0;
    c_mn = 0;
    c_sc = 0;
    c_wd = 1;
    phase = 0;
    while (requests_queued < TARGET_ITEMS) begin
      settle();
      if (phase == 0) begin
        write_reg(asc_pkg::CFG_RING_MINUTES, 8'd255);
        write_reg(asc_pkg::CFG_OFF_HOUR, 8'd0);
        write_reg(asc_pkg::CFG_ON_HOUR, 8'd23);
      end else begin
        if ($urandom_range(0, 1)) begin
          r = $urandom_range(0, 9);
          write_reg(asc_pkg::CFG_RING_MINUTES, (r == 0) ? 8'd0 : (r == 1) ? 8'd255 :
                    (r < 4) ? 8'($urandom_range(2, 3)) : 8'd1);
        end
        if ($urandom_range(0, 1))
          write_reg(asc_pkg::CFG_OFF_HOUR, 8'($urandom_range(0, 23)));
        if ($urandom_range(0, 1))
          write_reg(asc_pkg::CFG_ON_HOUR, 8'($urandom_range(0, 23)));
      end
      for (s = 0; s < NUM_SLOTS; s++)
        if ($urandom_range(0, 3) != 0)
          queue_write(s, $urandom_range(0, 23), $urandom_range(0, 59),
                      $urandom_range(0, asc_pkg::REP_WEEKEND));
      t = $urandom_range(0, NUM_SLOTS - 1);
      aim_clock(t);
      n = $urandom_range(30, 110);
      repeat (n) begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          queue_tick($urandom_range(0, 31), $urandom_range(0, 63), $urandom_range(0, 63),
                     $urandom_range(0, 7), $urandom_range(0, 1), $urandom_range(0, 1),
                     $urandom_range(0, 7));
        end else if (r < 7) begin
          queue_write($urandom_range(0, 3), $urandom_range(0, 31), $urandom_range(0, 63),
                      $urandom_range(0, 15));
        end else if (r < 10) begin
          aim_clock($urandom_range(0, NUM_SLOTS - 1));
        end else begin
          queue_tick(c_hr, c_mn, c_sc, c_wd, $urandom_range(0, 39) == 0,
                     $urandom_range(0, 1), $urandom_range(1, 5));
          // advance one second
          c_sc++;
          if (c_sc >= 60) begin
            c_sc = 0;
            c_mn++;
          end
          if (c_mn >= 60) begin
            c_mn = 0;
            c_hr++;
          end
          if (c_hr >= 24) begin
            c_hr = 0;
            c_wd = c_wd % 7 + 1;
          end
        end
      end
      phase++;
    end
    settle();

    if (mismatches == 0 && awaited_responses.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/asc_pkg.sv
hw/rtl/asc_match.sv
hw/rtl/alarm_schedule_controller.sv
sim/alarm_schedule_controller_test.sv
